// ----- rtl/cfjv_pkg.sv -----
// ----------------------------------------------------------------------------
// cfjv_pkg
// types, codes and helpers shared by the canonical flat json validator
// ----------------------------------------------------------------------------
package cfjv_pkg;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [4:0] status;
    logic [4:0] field_count;
  } out_word_t;

  typedef enum logic [4:0] {
    PH_OPEN, PH_KEY_OPEN, PH_STR, PH_ESC,
    PH_HA0, PH_HA1, PH_HA2, PH_HA3, PH_LOW_BS, PH_LOW_U,
    PH_HB0, PH_HB1, PH_HB2, PH_HB3, PH_COLON, PH_VALUE,
    PH_ZERO, PH_DIGITS, PH_DELIM, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {ORD_EQ, ORD_GT, ORD_LT} ord_t;

  typedef enum logic [1:0] {CTL_IDLE, CTL_CMP, CTL_FIN} ctl_t;

  // status codes
  localparam logic [4:0] ST_BUSY      = 5'd0;
  localparam logic [4:0] ST_OK        = 5'd1;
  localparam logic [4:0] ERR_TRUNC    = 5'd2;
  localparam logic [4:0] ERR_HEX      = 5'd3;
  localparam logic [4:0] ERR_STRREQ   = 5'd4;
  localparam logic [4:0] ERR_NONASCII = 5'd5;
  localparam logic [4:0] ERR_ESC      = 5'd6;
  localparam logic [4:0] ERR_NONCANON = 5'd7;
  localparam logic [4:0] ERR_LOW_MISS = 5'd8;
  localparam logic [4:0] ERR_LOW_BAD  = 5'd9;
  localparam logic [4:0] ERR_UNPAIRED = 5'd10;
  localparam logic [4:0] ERR_BRACE    = 5'd11;
  localparam logic [4:0] ERR_KEYORDER = 5'd12;
  localparam logic [4:0] ERR_COLON    = 5'd13;
  localparam logic [4:0] ERR_INTEGER  = 5'd14;
  localparam logic [4:0] ERR_FIELDS   = 5'd15;
  localparam logic [4:0] ERR_DELIM    = 5'd16;
  localparam logic [4:0] ERR_TRAILING = 5'd17;
  localparam logic [4:0] ERR_LENGTH   = 5'd18;

  localparam logic [20:0] LIMIT_RESET = 21'd65536;
  localparam logic [20:0] BYTES_CAP   = 21'h1FFFFF;
  localparam logic [4:0]  COUNT_CAP   = 5'd16;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] b;
  } utf8_t;

  // hex digit value, 16 marks a bad digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] v;
    if (c >= CH_ZERO && c <= CH_NINE) v = 5'(c - CH_ZERO);
    else if (c >= CH_A && c <= CH_F) v = 5'(c - CH_A) + 5'd10;
    else v = 5'd16;
    return v;
  endfunction

  // utf-8 encoding of a code point of 128 or more
  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t u;
    u.b = '0;
    if (cp < 21'h800) begin
      u.len  = 3'd2;
      u.b[0] = {3'b110, cp[10:6]};
      u.b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      u.len  = 3'd3;
      u.b[0] = {4'b1110, cp[15:12]};
      u.b[1] = {2'b10, cp[11:6]};
      u.b[2] = {2'b10, cp[5:0]};
    end else begin
      u.len  = 3'd4;
      u.b[0] = {5'b11110, cp[20:18]};
      u.b[1] = {2'b10, cp[17:12]};
      u.b[2] = {2'b10, cp[11:6]};
      u.b[3] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

endpackage

// ----- rtl/canonical_flat_json_validator_unit.sv -----
// ----------------------------------------------------------------------------
// canonical_flat_json_validator_unit
// streaming checker for a strict, flat, canonical json object
// ----------------------------------------------------------------------------
// One message byte enters per word on the input channel and every byte gives
// one result word: status 0 while the message is in progress, and on the
// byte marked final the verdict (1 accepted, 2..17 first parse error, 18 when
// the length reaches the byte limit register) together with the field count.
// The previous key lives in a one-port-read ram, read ahead of the compare
// state in which each decoded key byte is checked against it and written;
// a byte passes a compare state for each key byte it yields, one per utf-8
// byte for the closing digit of a unicode escape in a key. The result sits
// in an output register, so a byte may be accepted while the previous
// result still waits. The user must write the byte limit register through
// cfg_write/cfg_data while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module canonical_flat_json_validator_unit
  import cfjv_pkg::*;
#(
  parameter int KEY_MAX_BYTES = 64,
  parameter int MAX_FIELDS    = 16,
  parameter int MAX_DIGITS    = 10
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word,
  input  logic      cfg_write,
  input  logic [20:0] cfg_data
);

  // widths that follow from the parameters
  localparam int CW = $clog2(KEY_MAX_BYTES + 2);
  localparam int AW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
  localparam int FW = $clog2(MAX_FIELDS + 1);
  localparam int DW = $clog2(MAX_DIGITS + 1);

  // control
  ctl_t ctl, ctl_next;
  logic accept;
  logic out_load;

  // message state
  phase_t      phase, phase_next;
  logic        in_key, in_key_next;
  logic [CW-1:0] cur_len, cur_len_next;
  logic [CW-1:0] prev_len, prev_len_next;
  ord_t        ord, ord_next;
  logic [FW-1:0] fields, fields_next;
  logic [DW-1:0] digits, digits_next;
  logic [15:0] esc, esc_next;
  logic [9:0]  hi_bits, hi_bits_next;
  logic [4:0]  err, err_next;
  logic [20:0] bytes;
  logic [20:0] limit;

  // final marker of the accepted byte and pending key bytes
  logic        fin_q;
  utf8_t       emit, emit_next;
  logic [1:0]  emit_idx;

  // key store
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic [CW-1:0] pos_inc;
  logic [7:0]    kbyte;

  assign accept   = in_valid && !in_stall;
  assign pos_inc  = cur_len + CW'(1);
  assign kbyte    = emit.b[emit_idx];
  // result register free or emptied this cycle
  assign out_load = (ctl == CTL_FIN) && (!out_valid || !out_stall);

  cfjv_ram #(.WIDTH(8), .DEPTH(KEY_MAX_BYTES), .AW(AW)) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---- control sequencer: next state ----
  always_comb begin
    ctl_next = ctl;
    unique case (ctl)
      CTL_IDLE: if (accept) ctl_next = (emit_next.len != 3'd0) ? CTL_CMP : CTL_FIN;
      CTL_CMP:  if (3'(emit_idx) + 3'd1 == emit.len) ctl_next = CTL_FIN;
      CTL_FIN:  if (!out_valid || !out_stall) ctl_next = CTL_IDLE;
      default:  ctl_next = CTL_IDLE;
    endcase
  end

  // ---- control sequencer: outputs ----
  always_comb begin
    in_stall  = (ctl != CTL_IDLE);
    // the read for each compare is issued in the cycle before it
    ram_raddr = (ctl == CTL_CMP) ? pos_inc[AW-1:0] : cur_len[AW-1:0];
    ram_we    = (ctl == CTL_CMP) && (cur_len < CW'(KEY_MAX_BYTES));
    ram_waddr = cur_len[AW-1:0];
    ram_wdata = kbyte;
  end

  // ---- parse step for one byte ----
  always_comb begin
    logic [7:0]  b;
    logic        digit;
    logic [4:0]  h;
    logic [15:0] cp16;
    logic        key_ok;

    b     = in_word.message_byte;
    digit = (b >= CH_ZERO) && (b <= CH_NINE);
    h     = hex_nibble(b);
    cp16  = {esc[11:0], h[3:0]};

    phase_next    = phase;
    in_key_next   = in_key;
    cur_len_next  = cur_len;
    prev_len_next = prev_len;
    ord_next      = ord;
    fields_next   = fields;
    digits_next   = digits;
    esc_next      = esc;
    hi_bits_next  = hi_bits;
    err_next      = err;
    emit_next     = '0;

    key_ok = (cur_len <= CW'(KEY_MAX_BYTES)) &&
             ((fields == '0) || (ord == ORD_GT) ||
              ((ord == ORD_EQ) && (cur_len > prev_len)));

    if (err == ST_BUSY) begin
      unique case (phase)
        PH_OPEN: begin
          if (b == CH_LBRACE) phase_next = PH_KEY_OPEN;
          else err_next = ERR_BRACE;
        end
        PH_KEY_OPEN: begin
          if (b != CH_QUOTE) err_next = ERR_STRREQ;
          else begin
            in_key_next  = 1'b1;
            cur_len_next = '0;
            ord_next     = ORD_EQ;
            phase_next   = PH_STR;
          end
        end
        PH_STR: begin
          if (b == CH_QUOTE) begin
            if (in_key) begin
              if (!key_ok) err_next = ERR_KEYORDER;
              else begin
                prev_len_next = cur_len;
                phase_next    = PH_COLON;
              end
            end else if (fields >= FW'(MAX_FIELDS)) begin
              err_next = ERR_FIELDS;
            end else begin
              fields_next = fields + FW'(1);
              phase_next  = PH_DELIM;
            end
          end else if (b < CH_SPACE || b > CH_TILDE) begin
            err_next = ERR_NONASCII;
          end else if (b == CH_BSLASH) begin
            phase_next = PH_ESC;
          end else if (in_key) begin
            emit_next.len  = 3'd1;
            emit_next.b[0] = b;
          end
        end
        PH_ESC: begin
          if (b == CH_BSLASH || b == CH_QUOTE) begin
            phase_next = PH_STR;
            if (in_key) begin
              emit_next.len  = 3'd1;
              emit_next.b[0] = b;
            end
          end else if (b == CH_U) begin
            esc_next   = '0;
            phase_next = PH_HA0;
          end else err_next = ERR_ESC;
        end
        PH_HA0, PH_HA1, PH_HA2, PH_HB0, PH_HB1, PH_HB2: begin
          if (h[4]) err_next = ERR_HEX;
          else begin
            esc_next   = cp16;
            phase_next = phase_t'(phase + 5'd1);
          end
        end
        PH_HA3: begin
          if (h[4]) err_next = ERR_HEX;
          else begin
            esc_next = cp16;
            if (cp16 < 16'd128) err_next = ERR_NONCANON;
            else if (cp16 >= 16'hD800 && cp16 <= 16'hDBFF) begin
              hi_bits_next = cp16[9:0];
              phase_next   = PH_LOW_BS;
            end else if (cp16 >= 16'hDC00 && cp16 <= 16'hDFFF) begin
              err_next = ERR_UNPAIRED;
            end else begin
              phase_next = PH_STR;
              if (in_key) emit_next = utf8_encode({5'd0, cp16});
            end
          end
        end
        PH_HB3: begin
          if (h[4]) err_next = ERR_HEX;
          else begin
            esc_next = cp16;
            if (cp16 < 16'hDC00 || cp16 > 16'hDFFF) err_next = ERR_LOW_BAD;
            else begin
              phase_next = PH_STR;
              if (in_key) emit_next = utf8_encode(21'h10000 + {1'b0, hi_bits, cp16[9:0]});
            end
          end
        end
        PH_LOW_BS: begin
          if (b == CH_BSLASH) phase_next = PH_LOW_U;
          else err_next = ERR_LOW_MISS;
        end
        PH_LOW_U: begin
          if (b == CH_U) begin
            esc_next   = '0;
            phase_next = PH_HB0;
          end else err_next = ERR_LOW_MISS;
        end
        PH_COLON: begin
          if (b == CH_COLON) phase_next = PH_VALUE;
          else err_next = ERR_COLON;
        end
        PH_VALUE: begin
          if (b == CH_QUOTE) begin
            in_key_next = 1'b0;
            phase_next  = PH_STR;
          end else if (digit) begin
            digits_next = DW'(1);
            phase_next  = (b == CH_ZERO) ? PH_ZERO : PH_DIGITS;
          end else err_next = ERR_INTEGER;
        end
        PH_ZERO, PH_DIGITS: begin
          if (digit) begin
            if (phase == PH_ZERO || digits >= DW'(MAX_DIGITS)) err_next = ERR_INTEGER;
            else digits_next = digits + DW'(1);
          end else if (fields >= FW'(MAX_FIELDS)) begin
            err_next = ERR_FIELDS;
          end else begin
            // end of number closes the field, then the delimiter
            fields_next = fields + FW'(1);
            if (b == CH_RBRACE) phase_next = PH_DONE;
            else if (b == CH_COMMA) phase_next = PH_KEY_OPEN;
            else err_next = ERR_DELIM;
          end
        end
        PH_DELIM: begin
          if (b == CH_RBRACE) phase_next = PH_DONE;
          else if (b == CH_COMMA) phase_next = PH_KEY_OPEN;
          else err_next = ERR_DELIM;
        end
        PH_DONE: err_next = ERR_TRAILING;
        default: err_next = ERR_TRAILING;
      endcase
    end
  end

  // ---- end-of-message verdict ----
  logic [FW-1:0] fields_fin;
  logic [4:0]    err_fin;
  logic [4:0]    status_fin;
  logic [FW+4:0] fields_wide;
  logic [4:0]    count_fin;

  always_comb begin
    fields_fin = fields;
    err_fin    = err;
    if (fin_q && err == ST_BUSY && phase != PH_DONE) begin
      if (phase == PH_ZERO || phase == PH_DIGITS) begin
        // the pending number still completes its field
        if (fields >= FW'(MAX_FIELDS)) err_fin = ERR_FIELDS;
        else begin
          fields_fin = fields + FW'(1);
          err_fin    = ERR_TRUNC;
        end
      end else if (phase == PH_VALUE) err_fin = ERR_INTEGER;
      else err_fin = ERR_TRUNC;
    end
    if (!fin_q) status_fin = ST_BUSY;
    else if (bytes >= limit) status_fin = ERR_LENGTH;
    else if (err_fin != ST_BUSY) status_fin = err_fin;
    else status_fin = ST_OK;
    fields_wide = (FW + 5)'(fields_fin);
    count_fin   = (fields_wide > (FW + 5)'(COUNT_CAP)) ? COUNT_CAP : fields_wide[4:0];
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl       <= CTL_IDLE;
      out_valid <= 1'b0;
      limit     <= LIMIT_RESET;
      phase     <= PH_OPEN;
      in_key    <= 1'b1;
      cur_len   <= '0;
      prev_len  <= '0;
      ord       <= ORD_EQ;
      fields    <= '0;
      digits    <= '0;
      esc       <= '0;
      hi_bits   <= '0;
      err       <= ST_BUSY;
      bytes     <= '0;
      fin_q     <= 1'b0;
      emit_idx  <= '0;
    end else begin
      ctl <= ctl_next;
      if (cfg_write) limit <= cfg_data;

      // load a new result word, or drop the one taken by the receiver
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      unique case (ctl)
        CTL_IDLE: begin
          if (accept) begin
            fin_q    <= in_word.final_byte;
            emit     <= emit_next;
            emit_idx <= '0;
            phase    <= phase_next;
            in_key   <= in_key_next;
            cur_len  <= cur_len_next;
            prev_len <= prev_len_next;
            ord      <= ord_next;
            fields   <= fields_next;
            digits   <= digits_next;
            esc      <= esc_next;
            hi_bits  <= hi_bits_next;
            err      <= err_next;
            if (bytes != BYTES_CAP) bytes <= bytes + 21'd1;
          end
        end
        CTL_CMP: begin
          // compare against the previous key while still equal
          if (cur_len < CW'(KEY_MAX_BYTES) && ord == ORD_EQ && cur_len < prev_len) begin
            if (kbyte > ram_rdata) ord <= ORD_GT;
            else if (kbyte < ram_rdata) ord <= ORD_LT;
          end
          if (cur_len <= CW'(KEY_MAX_BYTES)) cur_len <= pos_inc;
          emit_idx <= emit_idx + 2'd1;
        end
        CTL_FIN: begin
          if (out_load) begin
            out_word.status      <= status_fin;
            out_word.field_count <= count_fin;
            if (fin_q) begin
              phase    <= PH_OPEN;
              in_key   <= 1'b1;
              cur_len  <= '0;
              prev_len <= '0;
              ord      <= ORD_EQ;
              fields   <= '0;
              digits   <= '0;
              esc      <= '0;
              hi_bits  <= '0;
              err      <= ST_BUSY;
              bytes    <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/cfjv_ram.sv -----
// ----------------------------------------------------------------------------
// cfjv_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module cfjv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the canonical flat json validator
// ----------------------------------------------------------------------------
// Feeds whole messages one byte per word and predicts each result word with
// its own copy of the parse state. The stimulus is mostly well-formed objects
// with random keys and values, some of them damaged, plus byte noise. The
// byte limit register is moved between phases, and both channel sides idle.
// ----------------------------------------------------------------------------
module testbench;
  import cfjv_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_word;
  logic        cfg_write;
  logic [20:0] cfg_data;

  canonical_flat_json_validator_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data)
  );

  // verdicts predicted for bytes already offered, oldest first
  out_word_t verdict_q[$];
  int        fail_count;
  int        send_pct;
  int        recv_pct;
  int        hold_req;
  int        hold_ack;
  int        hold_left;
  int        bytes_sent;
  int        msgs_sent;
  bit [31:0] verdicts_seen;
  logic [7:0] msg[$];

  // ---------------------------------------------------------------------------
  // shadow copy of the parser state
  // ---------------------------------------------------------------------------
  phase_t      ph;
  logic [7:0]  prev_key [64];
  int unsigned prev_len;
  int unsigned cur_len;
  ord_t        ord;
  int unsigned fields;
  int unsigned digits;
  logic [15:0] esc;
  logic [9:0]  hi_bits;
  logic [4:0]  first_err;
  logic [20:0] nbytes;
  logic [20:0] byte_limit;
  bit          in_key;

  function automatic void clear_msg();
    ph = PH_OPEN;
    prev_len = 0;
    cur_len = 0;
    ord = ORD_EQ;
    fields = 0;
    digits = 0;
    esc = '0;
    hi_bits = '0;
    first_err = ST_BUSY;
    nbytes = '0;
    in_key = 1'b1;
  endfunction

  // only the first error sticks
  function automatic void flag(logic [4:0] code);
    if (first_err == ST_BUSY) first_err = code;
  endfunction

  // fold one decoded key byte into the ordering state and the key store
  function automatic void key_byte(logic [7:0] b);
    int unsigned pos;
    pos = cur_len;
    if (!in_key) return;
    if (pos < 64) begin
      if (ord == ORD_EQ && pos < prev_len) begin
        if (b > prev_key[pos]) ord = ORD_GT;
        else if (b < prev_key[pos]) ord = ORD_LT;
      end
      prev_key[pos] = b;
    end
    if (cur_len <= 64) cur_len++;
  endfunction

  function automatic void key_point(int unsigned cp);
    if (cp < 'h800) begin
      key_byte(8'(8'hC0 | (cp >> 6)));
      key_byte(8'(8'h80 | (cp & 63)));
    end else if (cp < 'h10000) begin
      key_byte(8'(8'hE0 | (cp >> 12)));
      key_byte(8'(8'h80 | ((cp >> 6) & 63)));
      key_byte(8'(8'h80 | (cp & 63)));
    end else begin
      key_byte(8'(8'hF0 | ((cp >> 18) & 7)));
      key_byte(8'(8'h80 | ((cp >> 12) & 63)));
      key_byte(8'(8'h80 | ((cp >> 6) & 63)));
      key_byte(8'(8'h80 | (cp & 63)));
    end
  endfunction

  function automatic void close_key();
    bit ok;
    ok = cur_len <= 64 && (fields == 0 || ord == ORD_GT ||
                           (ord == ORD_EQ && cur_len > prev_len));
    if (!ok) begin
      flag(ERR_KEYORDER);
      return;
    end
    prev_len = cur_len;
    ph = PH_COLON;
  endfunction

  function automatic void close_field();
    if (fields >= 16) flag(ERR_FIELDS);
    else fields++;
  endfunction

  function automatic void take_delim(logic [7:0] b);
    if (b == CH_RBRACE) ph = PH_DONE;
    else if (b == CH_COMMA) ph = PH_KEY_OPEN;
    else flag(ERR_DELIM);
  endfunction

  function automatic void close_number(logic [7:0] b);
    close_field();
    if (first_err == ST_BUSY) take_delim(b);
  endfunction

  function automatic void hex_digit(logic [7:0] b);
    int unsigned h;
    int unsigned cp;
    if (b >= CH_ZERO && b <= CH_NINE) h = b - CH_ZERO;
    else if (b >= CH_A && b <= CH_F) h = b - CH_A + 10;
    else h = 16;
    if (h > 15) begin
      flag(ERR_HEX);
      return;
    end
    esc = {esc[11:0], 4'(h)};
    cp = esc;
    if (ph == PH_HA3) begin
      if (cp < 128) flag(ERR_NONCANON);
      else if (cp >= 'hD800 && cp <= 'hDBFF) begin
        hi_bits = 10'(cp - 'hD800);
        ph = PH_LOW_BS;
      end else if (cp >= 'hDC00 && cp <= 'hDFFF) flag(ERR_UNPAIRED);
      else begin
        key_point(cp);
        ph = PH_STR;
      end
    end else if (ph == PH_HB3) begin
      if (cp < 'hDC00 || cp > 'hDFFF) begin
        flag(ERR_LOW_BAD);
        return;
      end
      key_point('h10000 + (int'(hi_bits) << 10) + (cp - 'hDC00));
      ph = PH_STR;
    end else begin
      ph = phase_t'(ph + 1);
    end
  endfunction

  function automatic void parse(logic [7:0] b);
    bit digit;
    digit = b >= CH_ZERO && b <= CH_NINE;
    case (ph)
      PH_OPEN: begin
        if (b == CH_LBRACE) ph = PH_KEY_OPEN;
        else flag(ERR_BRACE);
      end
      PH_KEY_OPEN: begin
        if (b != CH_QUOTE) flag(ERR_STRREQ);
        else begin
          in_key = 1'b1;
          cur_len = 0;
          ord = ORD_EQ;
          ph = PH_STR;
        end
      end
      PH_STR: begin
        if (b == CH_QUOTE) begin
          if (in_key) close_key();
          else begin
            close_field();
            if (first_err == ST_BUSY) ph = PH_DELIM;
          end
        end else if (b < CH_SPACE || b > CH_TILDE) flag(ERR_NONASCII);
        else if (b == CH_BSLASH) ph = PH_ESC;
        else key_byte(b);
      end
      PH_ESC: begin
        if (b == CH_BSLASH || b == CH_QUOTE) begin
          key_byte(b);
          ph = PH_STR;
        end else if (b == CH_U) begin
          esc = '0;
          ph = PH_HA0;
        end else flag(ERR_ESC);
      end
      PH_LOW_BS: begin
        if (b == CH_BSLASH) ph = PH_LOW_U;
        else flag(ERR_LOW_MISS);
      end
      PH_LOW_U: begin
        if (b == CH_U) begin
          esc = '0;
          ph = PH_HB0;
        end else flag(ERR_LOW_MISS);
      end
      PH_COLON: begin
        if (b == CH_COLON) ph = PH_VALUE;
        else flag(ERR_COLON);
      end
      PH_VALUE: begin
        if (b == CH_QUOTE) begin
          in_key = 1'b0;
          ph = PH_STR;
        end else if (digit) begin
          digits = 1;
          ph = (b == CH_ZERO) ? PH_ZERO : PH_DIGITS;
        end else flag(ERR_INTEGER);
      end
      PH_ZERO: begin
        if (digit) flag(ERR_INTEGER);
        else close_number(b);
      end
      PH_DIGITS: begin
        if (!digit) close_number(b);
        else if (digits >= 10) flag(ERR_INTEGER);
        else digits++;
      end
      PH_DELIM: take_delim(b);
      PH_HA0, PH_HA1, PH_HA2, PH_HA3, PH_HB0, PH_HB1, PH_HB2, PH_HB3: hex_digit(b);
      default: flag(ERR_TRAILING);
    endcase
  endfunction

  // expected result word for one message byte
  function automatic out_word_t predict_verdict(logic [7:0] b, bit fin);
    out_word_t w;
    w.status = ST_BUSY;
    if (first_err == ST_BUSY) parse(b);
    if (nbytes != BYTES_CAP) nbytes++;
    if (fin) begin
      if (first_err == ST_BUSY && ph != PH_DONE) begin
        if (ph == PH_ZERO || ph == PH_DIGITS) begin
          close_field();
          flag(ERR_TRUNC);
        end else if (ph == PH_VALUE) flag(ERR_INTEGER);
        else flag(ERR_TRUNC);
      end
      if (nbytes >= byte_limit) w.status = ERR_LENGTH;
      else if (first_err != ST_BUSY) w.status = first_err;
      else w.status = ST_OK;
    end
    w.field_count = fields > 16 ? COUNT_CAP : 5'(fields);
    if (fin) clear_msg();
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // clock, reset and run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("timeout: %0d verdicts still pending", verdict_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall, or a long hold-off when one is requested
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_pct);
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // checker: every accepted result word against the oldest prediction
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected word, status", out_word.status, -1);
      end else begin
        want = verdict_q.pop_front();
        if (out_word.status != want.status)
          report_mismatch("status", out_word.status, want.status);
        if (out_word.field_count != want.field_count)
          report_mismatch("field_count", out_word.field_count, want.field_count);
        verdicts_seen[want.status] = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, bit fin);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    verdict_q.push_back(predict_verdict(b, fin));
    in_valid <= 1'b1;
    in_word  <= '{message_byte: b, final_byte: fin};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_msg();
    for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1);
    msgs_sent++;
  endtask

  task automatic send_text(string s);
    msg.delete();
    for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
    send_msg();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_limit(logic [20:0] v);
    drain();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    byte_limit = v;
  endtask

  // ---------------------------------------------------------------------------
  // message builder
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] hex_char(int unsigned n);
    return n < 10 ? 8'(CH_ZERO + n) : 8'(CH_A + n - 10);
  endfunction

  function automatic void push_uesc(int unsigned cp);
    msg.push_back(CH_BSLASH);
    msg.push_back(CH_U);
    for (int s = 12; s >= 0; s -= 4) msg.push_back(hex_char((cp >> s) & 15));
  endfunction

  // random string body, escapes included
  function automatic void push_body(int n);
    int r;
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        msg.push_back(CH_BSLASH);
        msg.push_back(CH_BSLASH);
      end else if (r == 1) begin
        msg.push_back(CH_BSLASH);
        msg.push_back(CH_QUOTE);
      end else if (r == 2) begin
        push_uesc($urandom_range(0, 1) ? $urandom_range(128, 'hD7FF)
                                       : $urandom_range('hE000, 'hFFFF));
      end else if (r == 3) begin
        push_uesc($urandom_range('hD800, 'hDBFF));
        push_uesc($urandom_range('hDC00, 'hDFFF));
      end else begin
        do c = 8'($urandom_range(32, 126));
        while (c == CH_QUOTE || c == CH_BSLASH);
        msg.push_back(c);
      end
    end
  endfunction

  // mostly well-formed object with ascending keys, then maybe damaged
  function automatic void build_msg();
    int n;
    int r;
    int nd;
    int pos;
    string pick;
    r = $urandom_range(0, 39);
    n = (r == 0) ? 17 : (r == 1) ? 16 : $urandom_range(1, 4);
    msg.delete();
    msg.push_back(CH_LBRACE);
    for (int i = 0; i < n; i++) begin
      if (i > 0) msg.push_back(CH_COMMA);
      msg.push_back(CH_QUOTE);
      // leading bytes rise with the field index, so keys ascend
      msg.push_back(8'(65 + 3 * i + $urandom_range(0, 2)));
      push_body($urandom_range(0, 29) == 0 ? $urandom_range(58, 68) : $urandom_range(0, 4));
      msg.push_back(CH_QUOTE);
      msg.push_back(CH_COLON);
      if ($urandom_range(0, 1)) begin
        msg.push_back(CH_QUOTE);
        push_body($urandom_range(0, 5));
        msg.push_back(CH_QUOTE);
      end else if ($urandom_range(0, 5) == 0) begin
        msg.push_back(CH_ZERO);
      end else begin
        nd = $urandom_range(0, 7) == 0 ? $urandom_range(9, 11) : $urandom_range(1, 4);
        msg.push_back(8'($urandom_range(49, 57)));
        for (int d = 1; d < nd; d++) msg.push_back(8'($urandom_range(48, 57)));
      end
    end
    msg.push_back(CH_RBRACE);
    r = $urandom_range(0, 9);
    pos = $urandom_range(0, msg.size() - 1);
    pick = "{}\":,\\u09af ";
    case (r)
      6: msg[pos] = 8'($urandom_range(0, 255));
      7: while (msg.size() > pos + 1) void'(msg.pop_back());
      8: repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom_range(0, 255)));
      9: msg[pos] = pick[$urandom_range(0, pick.len() - 1)];
      default: ;
    endcase
  endfunction

  function automatic void build_noise();
    msg.delete();
    repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom_range(0, 255)));
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    send_text("{}");                                 // a key string is required
    send_text("x");                                  // no opening brace
    send_text("{\"a\":9,\"b\":\"\\u00e9\\ud83d\\ude00\"}");
    send_text("{\"b\":0,\"a\":1}");                  // keys out of order
    send_text("{\"a\":01}");                         // leading zero
    send_text("{\"a\":12345678901}");                // eleven digits
    send_text("{\"a\":42");                          // ends inside a number
    send_text("{\"a\":");                            // ends where a value starts
    send_text("{\"a\"1}");                           // colon missing
    send_text("{\"a\":\"\\u0041\"}");                // escape below 128
    send_text("{\"a\":\"\\ud800x\"}");               // low surrogate missing
    send_text("{\"a\":\"\\ud800\\u0041\"}");         // low surrogate invalid
    send_text("{\"a\":\"\\udc00\"}");                // unpaired low half
    send_text("{\"a\":\"\\q\"}");                    // bad escape
    send_text("{\"a\":\"\\uzz\"}");                  // bad hex digit
    send_text("{\"a\":\"\351\"}");                   // non-ascii byte
    send_text("{\"a\":1;");                          // bad delimiter
    send_text("{\"a\":1}}");                         // trailing byte
    send_text("{\"a\":1,\"a\":2}");                  // duplicate key
    send_text("{\"ab\":1,\"a\":2}");                 // shorter key after prefix
  endtask

  task automatic test_random(int budget, int s_pct, int r_pct);
    int stop;
    send_pct = s_pct;
    recv_pct = r_pct;
    stop = bytes_sent + budget;
    while (bytes_sent < stop) begin
      if ($urandom_range(0, 9) == 0) build_noise();
      else build_msg();
      send_msg();
    end
  endtask

  task automatic test_limits();
    write_limit(21'd2);                              // a two-byte limit
    test_random(40, 0, 0);
    write_limit(21'd24);                             // some messages just fit
    test_random(120, 5, 20);
    write_limit(21'd1048576);                        // a large limit, below the 21-bit maximum
    test_random(50, 0, 0);
    write_limit(LIMIT_RESET);
  endtask

  // hold the receiver off long enough for the block to fill and stall input
  task automatic test_backpressure();
    send_pct = 0;
    recv_pct = 0;
    hold_req++;
    repeat (6) begin
      build_msg();
      send_msg();
    end
    // sender pauses until every verdict is back
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    build_msg();
    send_msg();
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_word   <= '0;
    cfg_write <= 1'b0;
    cfg_data  <= '0;
    fail_count = 0;
    send_pct = 0;
    recv_pct = 0;
    hold_req = 0;
    hold_ack = 0;
    hold_left = 0;
    bytes_sent = 0;
    msgs_sent = 0;
    verdicts_seen = '0;
    byte_limit = LIMIT_RESET;
    clear_msg();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(300, 9, 55);
    test_random(300, 55, 9);
    test_random(250, 0, 0);
    test_limits();
    test_backpressure();
    drain();

    $display("covered %0d messages, %0d bytes, under several byte limits and idle mixes",
             msgs_sent, bytes_sent);
    $display("verdict codes observed (bit per code): %b", verdicts_seen[18:0]);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
